### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is high.
`define KSE_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Check a property on every rising edge, reset included.
`define KSE_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

### src/kse_pkg.sv
`default_nettype none

package kse_pkg;

  localparam int NUM_DIGITS = 4;

  localparam logic [4:0] GLYPH_BLANK = 5'd16;
  localparam logic [4:0] GLYPH_DASH  = 5'd17;
  localparam logic [4:0] MULTI_CODE  = 5'd17;
  localparam logic [4:0] NO_KEY_CODE = 5'd0;
  localparam logic [3:0] KEY_STAR    = 4'd14;
  localparam logic [3:0] KEY_HASH    = 4'd15;
  localparam logic [3:0] KEY_A       = 4'd10;
  localparam logic [3:0] KEY_B       = 4'd11;
  localparam logic [3:0] KEY_C       = 4'd12;
  localparam logic [3:0] KEY_D       = 4'd13;

  typedef struct packed {
    logic [3:0] cols_row0;
    logic [3:0] cols_row1;
    logic [3:0] cols_row2;
    logic [3:0] cols_row3;
  } scan_t;

  typedef struct packed {
    logic       key_pressed;
    logic [3:0] key_value;
    logic       overflow_flag;
    logic [4:0] digit_code0;
    logic [4:0] digit_code1;
    logic [4:0] digit_code2;
    logic [4:0] digit_code3;
    logic [7:0] segments0;
    logic [7:0] segments1;
    logic [7:0] segments2;
    logic [7:0] segments3;
  } result_t;

  // Decoded key of one scan.
  typedef struct packed {
    logic       pressed;
    logic [3:0] value;
  } key_t;

  // Entry buffer contents after a transfer.
  typedef struct packed {
    logic                             overflow;
    logic [3:0]                       last_key;
    logic [NUM_DIGITS-1:0][4:0]       digits;
  } entry_t;

  // Scan code to telephone-layout key value.
  function automatic logic [3:0] key_map(input logic [4:0] code);
    logic [3:0] v;
    case (code)
      5'd1:    v = 4'd1;
      5'd2:    v = 4'd2;
      5'd3:    v = 4'd3;
      5'd4:    v = KEY_A;
      5'd5:    v = 4'd4;
      5'd6:    v = 4'd5;
      5'd7:    v = 4'd6;
      5'd8:    v = KEY_B;
      5'd9:    v = 4'd7;
      5'd10:   v = 4'd8;
      5'd11:   v = 4'd9;
      5'd12:   v = KEY_C;
      5'd13:   v = KEY_STAR;
      5'd14:   v = 4'd0;
      5'd15:   v = KEY_HASH;
      5'd16:   v = KEY_D;
      5'd17:   v = KEY_D;
      default: v = 4'd0;
    endcase
    return v;
  endfunction

  // Glyph code to active-low seven-segment pattern.
  function automatic logic [7:0] glyph_segments(input logic [4:0] code);
    logic [7:0] s;
    case (code)
      5'd0:    s = 8'hc0;
      5'd1:    s = 8'hf9;
      5'd2:    s = 8'ha4;
      5'd3:    s = 8'hb0;
      5'd4:    s = 8'h99;
      5'd5:    s = 8'h92;
      5'd6:    s = 8'h82;
      5'd7:    s = 8'hd8;
      5'd8:    s = 8'h80;
      5'd9:    s = 8'h90;
      5'd10:   s = 8'h88;
      5'd11:   s = 8'h83;
      5'd12:   s = 8'hc4;
      5'd13:   s = 8'ha1;
      5'd14:   s = 8'h84;
      5'd15:   s = 8'h8e;
      5'd16:   s = 8'hff;
      5'd17:   s = 8'hbf;
      default: s = 8'hff;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### src/kse_decode.sv
`default_nettype none

module kse_decode (
  input  wire kse_pkg::scan_t scan,
  output kse_pkg::key_t       key
);

  logic [3:0][3:0] rows;
  logic [4:0]      code;
  logic [1:0]      row_sel;
  logic [3:0]      cols;
  logic            found;

  assign rows = {scan.cols_row3, scan.cols_row2, scan.cols_row1, scan.cols_row0};

  // First row with any column set wins.
  always_comb begin
    found   = 1'b0;
    row_sel = 2'd0;
    for (int r = 3; r >= 0; r--) begin
      if (rows[r] != 4'd0) begin
        found   = 1'b1;
        row_sel = r[1:0];
      end
    end
  end

  assign cols = rows[row_sel];

  always_comb begin
    if (!found) begin
      code = kse_pkg::NO_KEY_CODE;
    end else begin
      case (cols)
        4'b0001: code = {1'b0, row_sel, 2'd0} + 5'd1;
        4'b0010: code = {1'b0, row_sel, 2'd1} + 5'd1;
        4'b0100: code = {1'b0, row_sel, 2'd2} + 5'd1;
        4'b1000: code = {1'b0, row_sel, 2'd3} + 5'd1;
        default: code = kse_pkg::MULTI_CODE;
      endcase
    end
  end

  assign key.pressed = found;
  assign key.value   = kse_pkg::key_map(code);

endmodule

`default_nettype wire

### src/kse_entry.sv
`default_nettype none

module kse_entry (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           advance,
  input  wire kse_pkg::key_t  key,
  output kse_pkg::entry_t     entry_next
);

  kse_pkg::entry_t entry;
  logic            released;
  logic            released_next;

  always_comb begin
    entry_next    = entry;
    released_next = released;
    if (key.pressed) begin
      entry_next.last_key = key.value;
      if (released) begin
        if (entry.digits[3] != 5'd0) begin
          // Buffer full: clear the upper digits and flag overflow.
          entry_next.digits[3] = 5'd0;
          entry_next.digits[2] = 5'd0;
          entry_next.digits[1] = 5'd0;
          entry_next.overflow  = 1'b1;
        end else begin
          entry_next.digits[3] = entry.digits[2];
          entry_next.digits[2] = entry.digits[1];
          entry_next.digits[1] = entry.digits[0];
          entry_next.overflow  = 1'b0;
        end
        released_next = 1'b0;
      end else begin
        entry_next.digits[0] = entry.overflow ? 5'd0 : {1'b0, key.value};
      end
    end else begin
      released_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.overflow <= 1'b0;
      entry.last_key <= 4'd0;
      entry.digits   <= {kse_pkg::NUM_DIGITS{kse_pkg::GLYPH_DASH}};
      released       <= 1'b0;
    end else if (advance) begin
      entry    <= entry_next;
      released <= released_next;
    end
  end

endmodule

`default_nettype wire

### src/keypad_scan_digit_entry_unit.sv
// Channel  Dir  Handshake                   Payload
// scan     in   scan_valid / scan_ready     kse_pkg::scan_t   (four row readings)
// result   out  result_valid / result_ready kse_pkg::result_t (key, flags, digits)
//
// One scan per clock while the result is not stalled. A transfer lands in the scan register;
// when that stage advances it is decoded, entered into the digit buffer and written to the
// result register.
// Reset clears both stages and sets all digits to dash.
// A stalled result holds the pipeline; scan_ready drops only when both stages are full.
`default_nettype none

`include "assert_macros.svh"

module keypad_scan_digit_entry_unit (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             scan_valid,
  output logic                  scan_ready,
  input  wire kse_pkg::scan_t   scan,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output kse_pkg::result_t      result
);

  logic             s1_valid;
  kse_pkg::scan_t   s1_scan;
  logic             s1_advance;
  kse_pkg::key_t    key;
  kse_pkg::entry_t  entry_next;
  kse_pkg::result_t result_next;
  logic             upper_clear;

  assign s1_advance = s1_valid && (!result_valid || result_ready);
  assign scan_ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (scan_ready) begin
      s1_valid <= scan_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_valid && scan_ready) begin
      s1_scan <= scan;
    end
  end

  kse_decode u_decode (
    .scan (s1_scan),
    .key  (key)
  );

  kse_entry u_entry (
    .clk        (clk),
    .rst        (rst),
    .advance    (s1_advance),
    .key        (key),
    .entry_next (entry_next)
  );

  always_comb begin
    result_next.key_pressed   = key.pressed;
    result_next.key_value     = entry_next.last_key;
    result_next.overflow_flag = entry_next.overflow;
    result_next.digit_code0   = entry_next.digits[0];
    result_next.digit_code1   = entry_next.digits[1];
    result_next.digit_code2   = entry_next.digits[2];
    result_next.digit_code3   = entry_next.digits[3];
    result_next.segments0     = kse_pkg::glyph_segments(entry_next.digits[0]);
    result_next.segments1     = kse_pkg::glyph_segments(entry_next.digits[1]);
    result_next.segments2     = kse_pkg::glyph_segments(entry_next.digits[2]);
    result_next.segments3     = kse_pkg::glyph_segments(entry_next.digits[3]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      result <= result_next;
    end
  end

  assign upper_clear = (result.digit_code3 == 5'd0) && (result.digit_code2 == 5'd0) &&
                       (result.digit_code1 == 5'd0);

  // While overflow is shown, the upper digits stay cleared.
  `KSE_ASSERT(a_overflow_clears, clk, rst, (result_valid && result.overflow_flag) |-> upper_clear)
  // A stage that advances always presents a result next cycle.
  `KSE_ASSERT(a_advance_fills, clk, rst, s1_advance |=> result_valid)
  // A scan transfer always occupies the input stage next cycle.
  `KSE_ASSERT(a_scan_lands, clk, rst, (scan_valid && scan_ready) |=> s1_valid)
  // Reset leaves both stages empty.
  `KSE_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> (!s1_valid && !result_valid))

endmodule

`default_nettype wire

### tb/sv/keypad_entry_checker.sv
module keypad_entry_checker
  import kse_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic scan_valid,
  input  wire logic scan_ready,
  input  scan_t     scan,
  input  wire logic result_valid,
  input  wire logic result_ready,
  input  result_t   result,
  output int        fails,
  output int        outstanding,
  output int        checked,
  output int        presses
);

  localparam logic [7:0] SEG_PATTERN [18] = '{
    8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hd8, 8'h80,
    8'h90, 8'h88, 8'hc4 ^ 8'h47, 8'hc4, 8'ha1, 8'h84, 8'h8e, 8'hff, 8'hbf
  };

  logic [4:0] digit_q [NUM_DIGITS];
  logic       released_q;
  logic       overflow_q;
  logic [3:0] last_key_q;

  result_t predicted_displays [$];

  function automatic logic [7:0] segments_of(input logic [4:0] code);
    return (code <= GLYPH_DASH) ? SEG_PATTERN[code] : 8'hff;
  endfunction

  // Decode one scan, update the entry buffer, and return the display it leaves.
  function automatic result_t enter_scan(input scan_t s);
    logic [3:0] rows [4];
    logic [4:0] code;
    int         grp;
    int         pos;
    int         v;
    result_t    r;
    rows[0] = s.cols_row0;
    rows[1] = s.cols_row1;
    rows[2] = s.cols_row2;
    rows[3] = s.cols_row3;
    code = NO_KEY_CODE;
    for (int i = 0; i < 4; i++) begin
      if (code == NO_KEY_CODE && rows[i] != 4'd0) begin
        case (rows[i])
          4'b0001: code = 5'(i * 4 + 1);
          4'b0010: code = 5'(i * 4 + 2);
          4'b0100: code = 5'(i * 4 + 3);
          4'b1000: code = 5'(i * 4 + 4);
          default: code = MULTI_CODE;
        endcase
      end
    end
    if (code != NO_KEY_CODE) begin
      grp = code / 4;
      pos = code % 4;
      if (pos != 0) begin
        v = grp * 3 + pos;
        if (v == 10) v = KEY_STAR;
        else if (v == 11) v = 0;
        else if (v == 12) v = KEY_HASH;
      end else begin
        v = grp + 9;
      end
      last_key_q = 4'(v);
      if (released_q) begin
        if (digit_q[3] != 5'd0) begin
          digit_q[3] = 5'd0;
          digit_q[2] = 5'd0;
          digit_q[1] = 5'd0;
          overflow_q = 1'b1;
        end else begin
          digit_q[3] = digit_q[2];
          digit_q[2] = digit_q[1];
          digit_q[1] = digit_q[0];
          overflow_q = 1'b0;
        end
        released_q = 1'b0;
      end else begin
        digit_q[0] = overflow_q ? 5'd0 : {1'b0, last_key_q};
      end
      presses++;
    end else begin
      released_q = 1'b1;
    end
    r.key_pressed   = (code != NO_KEY_CODE);
    r.key_value     = last_key_q;
    r.overflow_flag = overflow_q;
    r.digit_code0   = digit_q[0];
    r.digit_code1   = digit_q[1];
    r.digit_code2   = digit_q[2];
    r.digit_code3   = digit_q[3];
    r.segments0     = segments_of(digit_q[0]);
    r.segments1     = segments_of(digit_q[1]);
    r.segments2     = segments_of(digit_q[2]);
    r.segments3     = segments_of(digit_q[3]);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    fails++;
    if (fails <= 30) $display("[%0t] checker: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  task automatic check_display(input result_t got, input result_t want);
    check_field("key_pressed", got.key_pressed, want.key_pressed);
    check_field("key_value", got.key_value, want.key_value);
    check_field("overflow_flag", got.overflow_flag, want.overflow_flag);
    check_field("digit_code0", got.digit_code0, want.digit_code0);
    check_field("digit_code1", got.digit_code1, want.digit_code1);
    check_field("digit_code2", got.digit_code2, want.digit_code2);
    check_field("digit_code3", got.digit_code3, want.digit_code3);
    check_field("segments0", got.segments0, want.segments0);
    check_field("segments1", got.segments1, want.segments1);
    check_field("segments2", got.segments2, want.segments2);
    check_field("segments3", got.segments3, want.segments3);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DIGITS; i++) digit_q[i] = GLYPH_DASH;
      released_q  = 1'b0;
      overflow_q  = 1'b0;
      last_key_q  = 4'd0;
      predicted_displays.delete();
      fails       = 0;
      outstanding = 0;
      checked     = 0;
      presses     = 0;
    end else begin
      // Retire the result transfer before predicting a scan from the same edge.
      if (result_valid && result_ready) begin
        if (predicted_displays.size() == 0)
          report_mismatch("result transfer with no scan outstanding");
        else
          check_display(result, predicted_displays.pop_front());
        checked++;
      end
      if (scan_valid && scan_ready)
        predicted_displays.push_back(enter_scan(scan));
      outstanding = predicted_displays.size();
    end
  end

endmodule

### tb/sv/tb_top.sv
module tb_top;
  import kse_pkg::*;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    scan_valid   = 1'b0;
  logic    scan_ready;
  scan_t   scan         = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  int fails;
  int outstanding;
  int checked;
  int presses;
  int sent = 0;
  bit quiet = 1'b0;

  always #5 clk = ~clk;

  keypad_scan_digit_entry_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .scan_valid   (scan_valid),
    .scan_ready   (scan_ready),
    .scan         (scan),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  keypad_entry_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .scan_valid   (scan_valid),
    .scan_ready   (scan_ready),
    .scan         (scan),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .fails        (fails),
    .outstanding  (outstanding),
    .checked      (checked),
    .presses      (presses)
  );

  // Mostly short idle stretches, a few long ones, none while quiet.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic scan_t rows_to_scan(input logic [3:0] r0, input logic [3:0] r1,
                                         input logic [3:0] r2, input logic [3:0] r3);
    scan_t s;
    s.cols_row0 = r0;
    s.cols_row1 = r1;
    s.cols_row2 = r2;
    s.cols_row3 = r3;
    return s;
  endfunction

  function automatic scan_t key_at(input int row, input int col);
    logic [3:0] r [4];
    r = '{default: 4'd0};
    r[row] = 4'b0001 << col;
    return rows_to_scan(r[0], r[1], r[2], r[3]);
  endfunction

  // One press: rows above the active one are quiet, rows below carry noise.
  function automatic scan_t random_press();
    logic [3:0] r [4];
    int         row;
    r = '{default: 4'd0};
    row = $urandom_range(0, 3);
    if ($urandom_range(0, 9) == 0) r[row] = 4'($urandom_range(1, 15));
    else r[row] = 4'b0001 << $urandom_range(0, 3);
    for (int i = row + 1; i < 4; i++)
      if ($urandom_range(0, 1) == 1) r[i] = 4'($urandom_range(0, 15));
    return rows_to_scan(r[0], r[1], r[2], r[3]);
  endfunction

  task automatic send_scan(input scan_t s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      scan_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    scan_valid <= 1'b1;
    scan       <= s;
    do @(posedge clk); while (!scan_ready);
    sent++;
  endtask

  // Hold off the sender until every predicted display has come back.
  task automatic drain();
    scan_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    int n;
    wait (!rst);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        result_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      result_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin
    #5000000;
    $display("keypad_scan_digit_entry_unit: mismatch");
    $finish;
  end

  initial begin
    int    next_drain;
    int    hold;
    scan_t key;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Every key held without release: first press after reset writes digit 0.
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        send_scan(key_at(r, c));
    send_scan('0);
    // Multi-key row with later rows also active; top digit is a dash -> overflow.
    send_scan(rows_to_scan(4'd0, 4'b0110, 4'hf, 4'b0001));
    send_scan(key_at(3, 3));
    send_scan('0);
    // All columns in all rows; top digit is zero now -> shift.
    send_scan(rows_to_scan(4'hf, 4'hf, 4'hf, 4'hf));
    send_scan(key_at(2, 1));
    send_scan('0);
    drain();

    next_drain = sent + 400;
    while (sent < 1700) begin
      if ($urandom_range(0, 9) == 0) quiet = ~quiet;
      if (sent >= next_drain) begin
        drain();
        next_drain += 400;
      end
      if ($urandom_range(0, 4) != 0) begin
        key  = random_press();
        hold = $urandom_range(1, 4);
        repeat (hold) send_scan(($urandom_range(0, 3) == 0) ? random_press() : key);
        repeat ($urandom_range(1, 2)) send_scan('0);
      end else begin
        repeat ($urandom_range(1, 4))
          send_scan(rows_to_scan(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15))));
      end
    end

    scan_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);

    $display("%0d scans accepted, %0d displays checked, %0d of them with a key down",
             sent, checked, presses);
    $display("keys, multi-key rows, releases, shifts and overflow under random stalls");
    if (fails == 0 && outstanding == 0) begin
      $display("keypad_scan_digit_entry_unit: match");
    end else begin
      $display("keypad_scan_digit_entry_unit: mismatch");
    end
    $finish;
  end

endmodule
